>>> design/assert_macros.svh
// assertion macros used by the tagged frame stack unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// condition that holds at every clock edge out of reset
`define AST_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// same-cycle implication
`define AST_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define AST_ALWAYS(lbl, expr, msg)
`define AST_IMPLY(lbl, ante, cons, msg)
`define AST_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/tfs_pkg.sv
// types and codes of the tagged frame stack unit
package tfs_pkg;

	localparam int CMD_W    = 4;
	localparam int OPND_W   = 32;
	localparam int CNT_W    = 10;
	localparam int LIM_W    = 11;
	localparam int PTR_O_W  = 11;
	localparam int OUT_V_W  = 32;
	localparam logic [LIM_W-1:0] LIM_RESET = 11'd1024;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_REF  = 4'd0,
		CMD_PUSH_NUM  = 4'd1,
		CMD_POP_REF   = 4'd2,
		CMD_POP_NUM   = 4'd3,
		CMD_ALLOC     = 4'd4,
		CMD_RELEASE   = 4'd5,
		CMD_PUSH_LOC  = 4'd6,
		CMD_POP_LOC   = 4'd7,
		CMD_DROP      = 4'd8,
		CMD_PUSH_RET  = 4'd9,
		CMD_POP_RET   = 4'd10,
		CMD_RD_SLOT   = 4'd11,
		CMD_WR_SLOT   = 4'd12,
		CMD_SET_RET   = 4'd13
	} cmd_t;

	typedef enum logic [2:0] {
		STS_OK        = 3'd0,
		STS_OVERFLOW  = 3'd1,
		STS_UNDERFLOW = 3'd2,
		STS_REF_EXP   = 3'd3,
		STS_NUM_EXP   = 3'd4,
		STS_NO_FRAME  = 3'd5,
		STS_LOC_NREF  = 3'd6,
		STS_INDEX     = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ISSUE,
		S_EVAL,
		S_EVAL2,
		S_FILL,
		S_RESP
	} state_t;

	localparam logic [2:0] CFG_ADDR_LIMIT = 3'd0;

endpackage

>>> design/tfs_ram.sv
// generic single-write single-read ram with registered read data
module tfs_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> design/tagged_frame_stack_unit.sv
// tagged frame stack unit: top level with sequencer, slot ram and config port
//
// Stack of tagged slots for a stack virtual machine. Every slot holds a
// VALUE_WIDTH-bit value and a tag bit (1 = reference, 0 = number); the slots
// sit in one single-port-read, single-port-write ram with a registered read.
// Each command word on the s_ stream produces exactly one result word on the
// m_ stream. A small sequencer walks each command through the ram: an issue
// cycle does the checks that need no slot data and starts a read, an eval
// cycle checks the tag that came back and commits, and a response cycle
// loads the output register. Push, push return, drop, set return and any
// failing pre-check skip eval; pops, release, push local, slot read and
// slot write pass through eval; pop local adds a second eval step; frame
// allocate with n locals writes one null slot per cycle through the ram
// write port. One command is in flight at a time; s_tready is high only
// while the sequencer is idle, and a finished result waits in the output
// register without blocking the next accept. A failing command reports its
// status and leaves stack top, frame base, return register and slots as
// they were. The slot ram is not cleared after reset: only slots below the
// stack top are ever read and all of those have been written, so the block
// is ready right out of reset. slot_limit (reset 1024) sits at byte address
// 0 of the apb port; write it only while the block is idle.

`include "assert_macros.svh"

module tagged_frame_stack_unit #(
	parameter int DEPTH       = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// command words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // operand_value[31:0], count_or_index[41:32], zero fill
	input  logic [3:0]  s_tuser,   // command[3:0]
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // status[2:0], read_value[34:3], sp_after[45:35],
	                               // fp_after[56:46], return_after[88:57], zero fill
	output logic        m_tuser,   // read_is_ref
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int VW = VALUE_WIDTH;
	localparam int PW = $clog2(DEPTH + 1);                 // pointer width, holds DEPTH
	localparam int AW = $clog2(DEPTH);                     // slot address width
	localparam int XW = ((PW > tfs_pkg::LIM_W) ? PW : tfs_pkg::LIM_W) + 1; // compare width
	localparam int CW = (VW > XW) ? VW : XW;               // saved base compare width

	// sequencer and architectural state
	tfs_pkg::state_t  state_q, state_d;
	tfs_pkg::cmd_t    cmd_q;
	logic [VW-1:0]    val_q;
	logic [tfs_pkg::CNT_W-1:0] n_q;
	logic [PW-1:0]    top_q, top_d;
	logic [PW-1:0]    fb_q, fb_d;
	logic [VW-1:0]    ret_q, ret_d;
	logic [tfs_pkg::LIM_W-1:0] lim_q;
	logic [tfs_pkg::CNT_W-1:0] fill_q, fill_d;

	// result being built
	tfs_pkg::status_t st_q, st_d;
	logic [VW-1:0]    rv_q, rv_d;
	logic             rref_q, rref_d;

	// output register
	logic             m_tvalid_q;
	logic [95:0]      m_tdata_q;
	logic             m_tuser_q;

	// ram port
	logic             ram_we;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [VW:0]      ram_wdata, ram_rdata;
	logic             rd_tag;
	logic [VW-1:0]    rd_val;

	// widened operands for compares
	logic [XW-1:0]    top_x, fb_x, n_x, lim_x, idx_x;
	logic [CW-1:0]    saved_c, fbm1_c;

	tfs_pkg::status_t pre_st, eval_st, eval2_st;
	logic             pre_read;
	logic             accept, out_free;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == tfs_pkg::S_IDLE);

	assign rd_tag = ram_rdata[VW];
	assign rd_val = ram_rdata[VW-1:0];

	// effective limit is the smaller of slot_limit and DEPTH
	assign top_x = XW'(top_q);
	assign fb_x  = XW'(fb_q);
	assign n_x   = XW'(n_q);
	assign lim_x = (XW'(lim_q) > XW'(DEPTH)) ? XW'(DEPTH) : XW'(lim_q);
	assign idx_x = fb_x + n_x;   // local slot position

	assign saved_c = CW'(rd_val);
	assign fbm1_c  = CW'(fb_x - XW'(1));

	tfs_ram #(
		.WIDTH(VW + 1),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// checks that need no slot data
	always_comb begin
		pre_st   = tfs_pkg::STS_OK;
		pre_read = 1'b0;
		case (cmd_q) inside
			tfs_pkg::CMD_PUSH_REF, tfs_pkg::CMD_PUSH_NUM, tfs_pkg::CMD_PUSH_RET: begin
				if (top_x >= lim_x) pre_st = tfs_pkg::STS_OVERFLOW;
			end
			tfs_pkg::CMD_POP_REF, tfs_pkg::CMD_POP_NUM, tfs_pkg::CMD_POP_RET: begin
				pre_read = 1'b1;
				if (top_q == '0) pre_st = tfs_pkg::STS_UNDERFLOW;
			end
			tfs_pkg::CMD_ALLOC: begin
				// saved base plus n nulls must fit
				if (top_x >= lim_x || (n_x + XW'(1) + top_x) > lim_x)
					pre_st = tfs_pkg::STS_OVERFLOW;
			end
			tfs_pkg::CMD_RELEASE: begin
				pre_read = 1'b1;
				if (fb_q == '0) pre_st = tfs_pkg::STS_UNDERFLOW;
				else if (fb_x > top_x) pre_st = tfs_pkg::STS_INDEX;
			end
			tfs_pkg::CMD_PUSH_LOC: begin
				pre_read = 1'b1;
				if (fb_q == '0) pre_st = tfs_pkg::STS_NO_FRAME;
				else if (idx_x >= top_x) pre_st = tfs_pkg::STS_INDEX;
			end
			tfs_pkg::CMD_POP_LOC: begin
				// local must stay below the top after the pop
				pre_read = 1'b1;
				if (fb_q == '0) pre_st = tfs_pkg::STS_NO_FRAME;
				else if ((idx_x + XW'(1)) >= top_x) pre_st = tfs_pkg::STS_INDEX;
			end
			tfs_pkg::CMD_DROP: begin
				if (n_x > top_x) pre_st = tfs_pkg::STS_UNDERFLOW;
			end
			tfs_pkg::CMD_RD_SLOT, tfs_pkg::CMD_WR_SLOT: begin
				pre_read = 1'b1;
				if (n_x >= top_x) pre_st = tfs_pkg::STS_INDEX;
			end
			default: begin
			end
		endcase
	end

	// checks on the slot read back
	always_comb begin
		eval_st = tfs_pkg::STS_OK;
		case (cmd_q) inside
			tfs_pkg::CMD_POP_REF, tfs_pkg::CMD_POP_RET: begin
				if (!rd_tag) eval_st = tfs_pkg::STS_REF_EXP;
			end
			tfs_pkg::CMD_POP_NUM: begin
				if (rd_tag) eval_st = tfs_pkg::STS_NUM_EXP;
			end
			tfs_pkg::CMD_RELEASE: begin
				if (rd_tag) eval_st = tfs_pkg::STS_NUM_EXP;
				else if (saved_c > fbm1_c) eval_st = tfs_pkg::STS_INDEX;
			end
			tfs_pkg::CMD_PUSH_LOC: begin
				if (!rd_tag) eval_st = tfs_pkg::STS_LOC_NREF;
				else if (top_x >= lim_x) eval_st = tfs_pkg::STS_OVERFLOW;
			end
			tfs_pkg::CMD_POP_LOC: begin
				if (!rd_tag) eval_st = tfs_pkg::STS_LOC_NREF;
			end
			default: begin
			end
		endcase
		eval2_st = rd_tag ? tfs_pkg::STS_OK : tfs_pkg::STS_REF_EXP;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tfs_pkg::S_IDLE: begin
				if (accept) state_d = tfs_pkg::S_ISSUE;
			end
			tfs_pkg::S_ISSUE: begin
				if (pre_st != tfs_pkg::STS_OK) state_d = tfs_pkg::S_RESP;
				else if (pre_read) state_d = tfs_pkg::S_EVAL;
				else if (cmd_q == tfs_pkg::CMD_ALLOC && n_q != '0) state_d = tfs_pkg::S_FILL;
				else state_d = tfs_pkg::S_RESP;
			end
			tfs_pkg::S_EVAL: begin
				if (eval_st == tfs_pkg::STS_OK && cmd_q == tfs_pkg::CMD_POP_LOC)
					state_d = tfs_pkg::S_EVAL2;
				else
					state_d = tfs_pkg::S_RESP;
			end
			tfs_pkg::S_EVAL2: begin
				state_d = tfs_pkg::S_RESP;
			end
			tfs_pkg::S_FILL: begin
				if (fill_q == tfs_pkg::CNT_W'(1)) state_d = tfs_pkg::S_RESP;
			end
			tfs_pkg::S_RESP: begin
				if (out_free) state_d = tfs_pkg::S_IDLE;
			end
			default: begin
				state_d = tfs_pkg::S_IDLE;
			end
		endcase
	end

	// datapath and ram control per state
	always_comb begin
		top_d     = top_q;
		fb_d      = fb_q;
		ret_d     = ret_q;
		fill_d    = fill_q;
		st_d      = st_q;
		rv_d      = rv_q;
		rref_d    = rref_q;
		ram_we    = 1'b0;
		ram_waddr = top_q[AW-1:0];
		ram_wdata = {1'b1, rd_val};
		ram_raddr = top_q[AW-1:0];
		unique case (state_q)
			tfs_pkg::S_ISSUE: begin
				st_d   = pre_st;
				rv_d   = '0;
				rref_d = 1'b0;
				case (cmd_q) inside
					tfs_pkg::CMD_POP_REF, tfs_pkg::CMD_POP_NUM, tfs_pkg::CMD_POP_RET: begin
						ram_raddr = AW'(top_q - PW'(1));
					end
					tfs_pkg::CMD_RELEASE: begin
						ram_raddr = AW'(fb_q - PW'(1));
					end
					tfs_pkg::CMD_PUSH_LOC, tfs_pkg::CMD_POP_LOC: begin
						ram_raddr = idx_x[AW-1:0];
					end
					tfs_pkg::CMD_RD_SLOT, tfs_pkg::CMD_WR_SLOT: begin
						ram_raddr = n_x[AW-1:0];
					end
					default: begin
					end
				endcase
				if (pre_st == tfs_pkg::STS_OK) begin
					case (cmd_q) inside
						tfs_pkg::CMD_PUSH_REF, tfs_pkg::CMD_PUSH_NUM, tfs_pkg::CMD_PUSH_RET: begin
							ram_we    = 1'b1;
							ram_wdata = {cmd_q != tfs_pkg::CMD_PUSH_NUM,
								(cmd_q == tfs_pkg::CMD_PUSH_RET) ? ret_q : val_q};
							top_d     = top_q + PW'(1);
						end
						tfs_pkg::CMD_ALLOC: begin
							// saved base goes in as a number, new base is above it
							ram_we    = 1'b1;
							ram_wdata = {1'b0, VW'(fb_q)};
							top_d     = top_q + PW'(1);
							fb_d      = top_q + PW'(1);
							fill_d    = n_q;
						end
						tfs_pkg::CMD_DROP: begin
							top_d = PW'(top_x - n_x);
						end
						tfs_pkg::CMD_SET_RET: begin
							ret_d = val_q;
						end
						default: begin
						end
					endcase
				end
			end
			tfs_pkg::S_EVAL: begin
				st_d      = eval_st;
				ram_raddr = AW'(top_q - PW'(1));   // top slot for pop local
				if (eval_st == tfs_pkg::STS_OK) begin
					case (cmd_q) inside
						tfs_pkg::CMD_POP_REF, tfs_pkg::CMD_POP_RET: begin
							top_d  = top_q - PW'(1);
							rv_d   = rd_val;
							rref_d = 1'b1;
							if (cmd_q == tfs_pkg::CMD_POP_RET) ret_d = rd_val;
						end
						tfs_pkg::CMD_POP_NUM: begin
							top_d = top_q - PW'(1);
							rv_d  = rd_val;
						end
						tfs_pkg::CMD_RELEASE: begin
							top_d = fb_q - PW'(1);
							fb_d  = PW'(saved_c);
						end
						tfs_pkg::CMD_PUSH_LOC: begin
							ram_we    = 1'b1;
							ram_wdata = {1'b1, rd_val};
							top_d     = top_q + PW'(1);
						end
						tfs_pkg::CMD_RD_SLOT: begin
							rv_d   = rd_val;
							rref_d = rd_tag;
						end
						tfs_pkg::CMD_WR_SLOT: begin
							// slot keeps its tag
							ram_we    = 1'b1;
							ram_waddr = n_x[AW-1:0];
							ram_wdata = {rd_tag, val_q};
						end
						default: begin
						end
					endcase
				end
			end
			tfs_pkg::S_EVAL2: begin
				// pop local: top slot moves into the local, which is a ref
				st_d = eval2_st;
				if (eval2_st == tfs_pkg::STS_OK) begin
					top_d     = top_q - PW'(1);
					rv_d      = rd_val;
					rref_d    = 1'b1;
					ram_we    = 1'b1;
					ram_waddr = idx_x[AW-1:0];
					ram_wdata = {1'b1, rd_val};
				end
			end
			tfs_pkg::S_FILL: begin
				// one null reference per cycle
				ram_we    = 1'b1;
				ram_wdata = {1'b1, {VW{1'b0}}};
				top_d     = top_q + PW'(1);
				fill_d    = fill_q - tfs_pkg::CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfs_pkg::S_IDLE;
			top_q   <= '0;
			fb_q    <= '0;
			ret_q   <= '0;
			fill_q  <= '0;
			lim_q   <= tfs_pkg::LIM_RESET;
		end else begin
			state_q <= state_d;
			top_q   <= top_d;
			fb_q    <= fb_d;
			ret_q   <= ret_d;
			fill_q  <= fill_d;
			if (psel && penable && pwrite && pready && paddr == tfs_pkg::CFG_ADDR_LIMIT) begin
				lim_q <= pwdata[tfs_pkg::LIM_W-1:0];
			end
		end
	end

	// command word and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= tfs_pkg::cmd_t'(s_tuser);
			val_q <= VW'(s_tdata[tfs_pkg::OPND_W-1:0]);
			n_q   <= s_tdata[tfs_pkg::OPND_W +: tfs_pkg::CNT_W];
		end
		st_q   <= st_d;
		rv_q   <= rv_d;
		rref_q <= rref_d;
	end

	// output register, loaded once per command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == tfs_pkg::S_RESP && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tfs_pkg::S_RESP && out_free) begin
			m_tdata_q <= {7'd0,
				tfs_pkg::OUT_V_W'(ret_q),
				tfs_pkg::PTR_O_W'(fb_q),
				tfs_pkg::PTR_O_W'(top_q),
				tfs_pkg::OUT_V_W'(rv_q),
				st_q};
			m_tuser_q <= rref_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// register readback
	assign pready = 1'b1;
	assign prdata = (paddr == tfs_pkg::CFG_ADDR_LIMIT) ? 32'(lim_q) : 32'd0;

	`AST_ALWAYS(a_top_in_range, top_q <= PW'(DEPTH), "stack top beyond depth")
	`AST_IMPLY(a_fill_count, state_q == tfs_pkg::S_FILL, fill_q != '0, "fill with zero count")
	`AST_IMPLY(a_no_write_on_err, ram_we && state_q == tfs_pkg::S_ISSUE, pre_st == tfs_pkg::STS_OK, "slot written by failing command")
	`AST_NEXT(a_eval_err_hold, state_q == tfs_pkg::S_EVAL && eval_st != tfs_pkg::STS_OK, $stable(top_q) && $stable(fb_q) && $stable(ret_q), "failing command changed state")

endmodule
